### sv/ray_box_slab_intersect_core_defines.svh
// Assertion macros for the ray/box slab intersection core.
// Included by the top level; no other dependencies.
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RBSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;

  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  // Per-axis flags that ride alongside the divider pipeline
  typedef struct packed {
    logic [NUM_AXES-1:0] par_miss;  // zero direction and origin outside slab
    logic [NUM_AXES-1:0] dzero;     // zero direction: axis takes no part in near/far
  } axis_flags_t;

endpackage
`default_nettype wire

### sv/rbsi_div.sv
// Pipelined signed divider: (diff << FRAC_BITS) / dvs, truncated, saturated.
// One quotient bit per stage; stage enables come from the owner's valid chain.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_div #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int NW          = COORD_WIDTH + 1 + FRAC_BITS,
  parameter int DS          = NW + 2
) (
  input  wire logic                          clk,
  input  wire logic [DS-1:0]                 en,
  input  wire logic signed [COORD_WIDTH:0]   diff,
  input  wire logic signed [COORD_WIDTH-1:0] dvs,
  output logic signed [COORD_WIDTH-1:0]      quo
);

  localparam int CW = COORD_WIDTH;
  localparam logic [NW-1:0] LIM = {{(FRAC_BITS+2){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] rem [0:NW];
  logic [NW-1:0] nq  [0:NW];
  logic [CW-1:0] dm  [0:NW];
  logic          neg [0:NW];

  logic [CW:0]   diff_mag;
  logic [CW-1:0] dvs_mag;

  assign diff_mag = diff[CW] ? (~diff + 1'b1) : diff;
  assign dvs_mag  = dvs[CW-1] ? (~dvs + 1'b1) : dvs;

  // Take magnitudes and align the numerator
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= '0;
      nq[0]  <= {diff_mag, {FRAC_BITS{1'b0}}};
      dm[0]  <= dvs_mag;
      neg[0] <= diff[CW] ^ dvs[CW-1];
    end
  end

  // Restoring division, one bit per stage
  for (genvar k = 1; k <= NW; k++) begin : g_iter
    logic [CW:0] trial;
    logic [CW:0] sub;
    logic        ge;
    assign trial = {rem[k-1], nq[k-1][NW-1]};
    assign sub   = trial - {1'b0, dm[k-1]};
    assign ge    = trial >= {1'b0, dm[k-1]};
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? sub[CW-1:0] : trial[CW-1:0];
        nq[k]  <= {nq[k-1][NW-2:0], ge};
        dm[k]  <= dm[k-1];
        neg[k] <= neg[k-1];
      end
    end
  end

  // Apply sign and saturate
  always_ff @(posedge clk) begin
    if (en[NW+1]) begin
      if (!neg[NW] && nq[NW] > LIM) begin
        quo <= MAXV;
      end else if (neg[NW] && nq[NW] > LIM + 1'b1) begin
        quo <= MINV;
      end else if (neg[NW]) begin
        quo <= ~nq[NW][CW-1:0] + 1'b1;
      end else begin
        quo <= nq[NW][CW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### sv/ray_box_slab_intersect_core.sv
// Top level of the ray/box slab intersection core.
// Depends on rbsi_pkg, rbsi_div and ray_box_slab_intersect_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_box_slab_intersect_core_defines.svh"
// Tests one ray per request against an axis-aligned box held in six
// registers (min x/y/z at index 0..2, max x/y/z at 3..5), signed fixed point
// with FRAC_BITS fraction bits. Write the box only while no request is in
// flight. The pipeline takes one request per clock unless a held output has
// filled every stage, and returns hit and t_hit through the input stage, the
// six slab dividers, the order stage and the output stage; the dividers
// retire one quotient bit per stage. Each stage holds only when it is full
// and its successor holds, so bubbles collapse and the input keeps taking
// requests while a result waits, until every stage is full.
// On a miss t_hit is zero; on a hit it is the near distance, or the far
// distance when the origin lies inside the box.
module ray_box_slab_intersect_core
  import rbsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] origin_x,
  input  wire logic signed [COORD_WIDTH-1:0] origin_y,
  input  wire logic signed [COORD_WIDTH-1:0] origin_z,
  input  wire logic signed [COORD_WIDTH-1:0] dir_x,
  input  wire logic signed [COORD_WIDTH-1:0] dir_y,
  input  wire logic signed [COORD_WIDTH-1:0] dir_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic signed [COORD_WIDTH-1:0]      t_hit
);

  localparam int CW   = COORD_WIDTH;
  localparam int NW   = CW + 1 + FRAC_BITS;
  localparam int DS   = NW + 2;          // divider stages
  localparam int NSTG = DS + 3;          // input, divider, order, output
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // Box registers
  logic signed [CW-1:0] box_min [NUM_AXES];
  logic signed [CW-1:0] box_max [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X: box_min[0] <= cfg_wdata;
        REG_MIN_Y: box_min[1] <= cfg_wdata;
        REG_MIN_Z: box_min[2] <= cfg_wdata;
        REG_MAX_X: box_max[0] <= cfg_wdata;
        REG_MAX_Y: box_max[1] <= cfg_wdata;
        REG_MAX_Z: box_max[2] <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Valid chain: a stage advances when empty or when its successor advances
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 0: slab offsets and the zero-direction test
  logic signed [CW-1:0] org [NUM_AXES];
  logic signed [CW-1:0] dir [NUM_AXES];
  logic signed [CW:0]   diff_lo [NUM_AXES];
  logic signed [CW:0]   diff_hi [NUM_AXES];
  logic signed [CW-1:0] dir_q   [NUM_AXES];
  axis_flags_t          flags [0:DS];

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        diff_lo[a]        <= {box_min[a][CW-1], box_min[a]} - {org[a][CW-1], org[a]};
        diff_hi[a]        <= {box_max[a][CW-1], box_max[a]} - {org[a][CW-1], org[a]};
        dir_q[a]          <= dir[a];
        flags[0].dzero[a] <= (dir[a] == '0);
        flags[0].par_miss[a] <= (dir[a] == '0) &&
                                ((org[a] < box_min[a]) || (org[a] > box_max[a]));
      end
    end
  end

  // Stages 1..DS: six dividers, flags travel alongside
  logic signed [CW-1:0] t_lo [NUM_AXES];
  logic signed [CW-1:0] t_hi [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbsi_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk (clk),
      .en  (en[DS:1]),
      .diff(diff_lo[a]),
      .dvs (dir_q[a]),
      .quo (t_lo[a])
    );
    rbsi_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk (clk),
      .en  (en[DS:1]),
      .diff(diff_hi[a]),
      .dvs (dir_q[a]),
      .quo (t_hi[a])
    );
  end

  for (genvar s = 1; s <= DS; s++) begin : g_flags
    always_ff @(posedge clk) begin
      if (en[s]) begin
        flags[s] <= flags[s-1];
      end
    end
  end

  // Order stage: sort each slab's pair; parallel axes stand at the extremes
  logic signed [CW-1:0] tmin [NUM_AXES];
  logic signed [CW-1:0] tmax [NUM_AXES];
  logic                 par_any;

  always_ff @(posedge clk) begin
    if (en[DS+1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (flags[DS].dzero[a]) begin
          tmin[a] <= MINV;
          tmax[a] <= MAXV;
        end else if (t_lo[a] > t_hi[a]) begin
          tmin[a] <= t_hi[a];
          tmax[a] <= t_lo[a];
        end else begin
          tmin[a] <= t_lo[a];
          tmax[a] <= t_hi[a];
        end
      end
      par_any <= |flags[DS].par_miss;
    end
  end

  // Output stage: fold near/far and decide the hit
  logic signed [CW-1:0] near_t;
  logic signed [CW-1:0] far_t;
  logic                 miss;

  always_comb begin
    near_t = tmin[0];
    far_t  = tmax[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (tmin[a] > near_t) near_t = tmin[a];
      if (tmax[a] < far_t)  far_t  = tmax[a];
    end
    miss = par_any || (near_t > far_t) || far_t[CW-1];
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      hit   <= !miss;
      t_hit <= miss ? '0 : (near_t[CW-1] ? far_t : near_t);
    end
  end

  `RBSI_ASSERT_NOW(a_miss_zero, clk, rst, out_valid && !hit, t_hit == '0, "miss with nonzero distance")
  `RBSI_ASSERT_NOW(a_hit_nonneg, clk, rst, out_valid && hit, !t_hit[CW-1], "hit at negative distance")
  `RBSI_ASSERT_NOW(a_stall_full, clk, rst, !in_ready, &v, "input held with an empty stage")
  `RBSI_ASSERT_NEXT(a_drain, clk, rst, v[NSTG-2] && en[NSTG-1], out_valid, "result lost at output")

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for ray_box_slab_intersect_core: directed and random rays
// against a range of boxes, results checked against an in-bench slab predictor.
// Depends on rbsi_pkg and ray_box_slab_intersect_core.
`timescale 1ns / 1ps
module testbench
  import rbsi_pkg::*;
();

  localparam int CW = 32;
  localparam int FB = 16;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic            hit;
    logic [CW-1:0]   t_hit;
  } ray_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [CW-1:0] t_hit;

  // Box copy held by the predictor
  longint box_lo[3];
  longint box_hi[3];

  ray_result_t pending_hits[$];
  int fail_count = 0;
  longint cycle_count = 0;
  int stall_mode = 0;

  ray_box_slab_intersect_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .t_hit(t_hit)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run with a fail once the cycle count passes CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ray_box_slab_intersect_core regression: fail");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  // Slab test: per axis fold entry/exit distances into near/far
  function automatic ray_result_t predict_slab(longint o[3], longint d[3]);
    ray_result_t r;
    longint near_t, far_t, t1, t2, tmp;
    bit miss;
    near_t = MINV;
    far_t = MAXV;
    miss = 0;
    for (int a = 0; a < 3; a++) begin
      if (d[a] == 0) begin
        if (o[a] < box_lo[a] || o[a] > box_hi[a]) miss = 1;
      end else begin
        // SV signed division truncates toward zero, as the hardware does
        t1 = clamp_coord(((box_lo[a] - o[a]) * (64'sd1 << FB)) / d[a]);
        t2 = clamp_coord(((box_hi[a] - o[a]) * (64'sd1 << FB)) / d[a]);
        if (t1 > t2) begin
          tmp = t1; t1 = t2; t2 = tmp;
        end
        if (t1 > near_t) near_t = t1;
        if (t2 < far_t) far_t = t2;
      end
    end
    if (near_t > far_t || far_t < 0) miss = 1;
    r.hit = !miss;
    r.t_hit = miss ? '0 : ((near_t >= 0) ? near_t[CW-1:0] : far_t[CW-1:0]);
    return r;
  endfunction

  // Receiver: stall on a pattern chosen per phase, check each result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3, 0) != 0);
        2: out_ready <= (cycle_count[3:0] < 4'd11);
        default: out_ready <= ($urandom_range(1, 0) == 1);
      endcase
      if (out_valid && out_ready) begin
        if (pending_hits.size() == 0) begin
          $error("unexpected result hit=%0b t_hit=%0d", hit, t_hit);
          fail_count++;
        end else begin
          ray_result_t exp_r;
          exp_r = pending_hits.pop_front();
          if (hit !== exp_r.hit) begin
            $error("hit: expected %0b, got %0b", exp_r.hit, hit);
            fail_count++;
          end
          if (t_hit !== exp_r.t_hit) begin
            $error("t_hit: expected %0d, got %0d", $signed(exp_r.t_hit), t_hit);
            fail_count++;
          end
        end
      end
    end
  end

  // Drive one register write; the caller drops the write enable after the last one
  task automatic write_box_reg(cfg_reg_t idx, logic [CW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= REG_MIN_Z) box_lo[idx] = $signed(val);
    else box_hi[idx - REG_MAX_X] = $signed(val);
  endtask

  // Wait until every result is back, then let the pipeline settle
  task automatic drain_pipeline();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_box(logic [CW-1:0] lx, ly, lz, hx, hy, hz);
    drain_pipeline();
    write_box_reg(REG_MIN_X, lx);
    write_box_reg(REG_MIN_Y, ly);
    write_box_reg(REG_MIN_Z, lz);
    write_box_reg(REG_MAX_X, hx);
    write_box_reg(REG_MAX_Y, hy);
    write_box_reg(REG_MAX_Z, hz);
    cfg_wr_en <= 1'b0;
  endtask

  // Send one request; hold valid and payload until accepted
  task automatic send_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
    longint o[3], d[3];
    in_valid <= 1'b1;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    o[0] = $signed(ox); o[1] = $signed(oy); o[2] = $signed(oz);
    d[0] = $signed(dx); d[1] = $signed(dy); d[2] = $signed(dz);
    do @(posedge clk); while (!in_ready);
    pending_hits.push_back(predict_slab(o, d));
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(int scale);
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000 | $urandom_range(1, 0);
      1: return 32'h7FFF_FFFF - $urandom_range(1, 0);
      2: return '0;
      3: return $urandom();
      default: return $signed($urandom_range(2 * scale, 0)) - scale;
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_dir();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return $urandom_range(1, 0) ? 32'sd1 : -32'sd1;
      2: return $urandom();
      default: return $signed($urandom_range(32'h40000, 0)) - 32'sh20000;
    endcase
  endfunction

  // Unit box, zero-direction cases, extremes, saturated distances
  task automatic test_directed();
    localparam logic [CW-1:0] ONE = 32'h0001_0000;
    load_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_ray(-5 * ONE, 0, 0, ONE, 0, 0);            // head-on hit
    send_ray(5 * ONE, 0, 0, ONE, 0, 0);             // box behind ray
    send_ray(0, 0, 0, ONE, ONE, ONE);               // origin inside
    send_ray(-5 * ONE, 3 * ONE, 0, ONE, 0, 0);      // parallel, outside slab
    send_ray(-5 * ONE, ONE, ONE, ONE, 0, 0);        // parallel, on slab edge
    send_ray(0, 0, 0, 0, 0, 0);                     // zero direction inside
    send_ray(-5 * ONE, 0, 0, 32'sd1, 0, 0);         // tiny direction saturates
    send_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ray(-5 * ONE, -5 * ONE, 0, ONE, 32'h0000_8000, 0);  // grazing diagonal miss
    idle_cycles(1);
    // Extreme box, then an inverted one
    load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(0, 0, 0, ONE, ONE, ONE);
    send_ray(32'h8000_0000, 0, 0, 32'sd1, 0, 0);
    send_ray(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    idle_cycles(1);
    load_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(-5 * ONE, 0, 0, ONE, 0, 0);
    send_ray(0, 0, 0, ONE, ONE, ONE);
    idle_cycles(1);
  endtask

  // Random rays in bursts, with idle gaps after most bursts
  task automatic test_random(int count, int scale, int mode);
    int n;
    stall_mode = mode;
    n = 0;
    while (n < count) begin
      int burst;
      burst = $urandom_range(20, 1);
      for (int i = 0; i < burst && n < count; i++, n++) begin
        send_ray(rand_coord(scale), rand_coord(scale), rand_coord(scale),
                 rand_dir(), rand_dir(), rand_dir());
      end
      if ($urandom_range(3, 0) != 0) idle_cycles($urandom_range(6, 1));
    end
    idle_cycles(1);
  endtask

  task automatic test_random_box(int scale);
    logic [CW-1:0] lo[3], hi[3];
    for (int a = 0; a < 3; a++) begin
      lo[a] = $signed($urandom_range(scale, 0)) - scale;
      hi[a] = $signed($urandom_range(scale, 0));
      if ($urandom_range(9, 0) == 0) hi[a] = $urandom();  // occasional wild bound
    end
    load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int phase = 0; phase < 8; phase++) begin
      test_random_box(32'h0008_0000 << (phase % 4));
      test_random(165, 32'h000A_0000, phase % 4);
    end
    drain_pipeline();
    if (fail_count == 0)
      $display("ray_box_slab_intersect_core regression: pass");
    else
      $display("ray_box_slab_intersect_core regression: fail");
    $finish;
  end

endmodule
